>>> sv/mrg_pkg.sv
// shared types and constants for the midi controller ramp generator
`default_nettype none

package mrg_pkg;

    localparam int TRIGGERS = 8;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [4:0]        RST_MIDI_CHANNEL   = 5'd1;
    localparam logic [6:0]        RST_CONTROL_NUMBER = 7'd0;
    localparam logic [6:0]        RST_MIN_VELOCITY   = 7'd20;
    localparam logic signed [7:0] RST_INITIAL_START  = -8'sd1;
    localparam logic signed [7:0] RST_INITIAL_END    = -8'sd1;
    localparam logic signed [7:0] RST_INITIAL_STEP   = 8'sd0;
    localparam logic signed [7:0] RST_LAST_SENT      = -8'sd1;

    localparam logic signed [17:0] LEVEL_MAX = 18'sd127;

    typedef enum logic [2:0] {
        FN_TICK      = 3'd0,
        FN_NOTE_ON   = 3'd1,
        FN_STEP_UP   = 3'd2,
        FN_STEP_DOWN = 3'd3,
        FN_START     = 3'd4,
        FN_END       = 3'd5,
        FN_LOAD      = 3'd6
    } func_t;

    typedef enum logic [2:0] {
        REG_MIDI_CHANNEL   = 3'd0,
        REG_CONTROL_NUMBER = 3'd1,
        REG_MIN_VELOCITY   = 3'd2,
        REG_INITIAL_START  = 3'd3,
        REG_INITIAL_END    = 3'd4,
        REG_INITIAL_STEP   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [2:0]        func;
        logic [62:0]       time_us;
        logic [6:0]        note;
        logic [6:0]        velocity;
        logic [2:0]        slot;
        logic [31:0]       trig_delay;
        logic signed [7:0] trig_start;
        logic signed [7:0] trig_end;
        logic signed [7:0] trig_step;
    } item_t;

    typedef struct packed {
        logic              start_we;
        logic              end_we;
        logic              step_we;
        logic signed [7:0] value;
    } init_load_t;

    typedef struct packed {
        logic [4:0] midi_channel;
        logic [6:0] control_number;
        logic [6:0] min_velocity;
        init_load_t init;
    } cfg_t;

    typedef struct packed {
        logic [6:0]        note;
        logic [31:0]       delay;
        logic signed [7:0] start;
        logic signed [7:0] stop;
        logic signed [7:0] step;
    } trig_word_t;

    typedef struct packed {
        logic              hit;
        logic [31:0]       delay;
        logic signed [7:0] start;
        logic signed [7:0] stop;
        logic signed [7:0] step;
    } match_t;

endpackage

`default_nettype wire

>>> sv/mrg_apb_regs.sv
// apb configuration registers of the ramp generator
`default_nettype none

module mrg_apb_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mrg_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [mrg_pkg::DATA_W-1:0]    pwdata,
    output logic      [mrg_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    output mrg_pkg::cfg_t                      cfg
);

    logic [4:0]        midi_channel_reg;
    logic [6:0]        control_number_reg;
    logic [6:0]        min_velocity_reg;
    logic signed [7:0] initial_start_reg;
    logic signed [7:0] initial_end_reg;
    logic signed [7:0] initial_step_reg;
    logic              wr_en;
    mrg_pkg::reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = mrg_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            midi_channel_reg   <= mrg_pkg::RST_MIDI_CHANNEL;
            control_number_reg <= mrg_pkg::RST_CONTROL_NUMBER;
            min_velocity_reg   <= mrg_pkg::RST_MIN_VELOCITY;
            initial_start_reg  <= mrg_pkg::RST_INITIAL_START;
            initial_end_reg    <= mrg_pkg::RST_INITIAL_END;
            initial_step_reg   <= mrg_pkg::RST_INITIAL_STEP;
        end
        else if (wr_en)
        begin
            unique case (idx)
                mrg_pkg::REG_MIDI_CHANNEL:   midi_channel_reg   <= pwdata[4:0];
                mrg_pkg::REG_CONTROL_NUMBER: control_number_reg <= pwdata[6:0];
                mrg_pkg::REG_MIN_VELOCITY:   min_velocity_reg   <= pwdata[6:0];
                mrg_pkg::REG_INITIAL_START:  initial_start_reg  <= $signed(pwdata[7:0]);
                mrg_pkg::REG_INITIAL_END:    initial_end_reg    <= $signed(pwdata[7:0]);
                mrg_pkg::REG_INITIAL_STEP:   initial_step_reg   <= $signed(pwdata[7:0]);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            mrg_pkg::REG_MIDI_CHANNEL:   prdata = 32'(midi_channel_reg);
            mrg_pkg::REG_CONTROL_NUMBER: prdata = 32'(control_number_reg);
            mrg_pkg::REG_MIN_VELOCITY:   prdata = 32'(min_velocity_reg);
            mrg_pkg::REG_INITIAL_START:  prdata = 32'(unsigned'(initial_start_reg));
            mrg_pkg::REG_INITIAL_END:    prdata = 32'(unsigned'(initial_end_reg));
            mrg_pkg::REG_INITIAL_STEP:   prdata = 32'(unsigned'(initial_step_reg));
            default:                     prdata = '0;
        endcase
    end

    // settings, and pulses reloading live ramp settings
    assign cfg.midi_channel   = midi_channel_reg;
    assign cfg.control_number = control_number_reg;
    assign cfg.min_velocity   = min_velocity_reg;
    assign cfg.init.start_we  = wr_en && (idx == mrg_pkg::REG_INITIAL_START);
    assign cfg.init.end_we    = wr_en && (idx == mrg_pkg::REG_INITIAL_END);
    assign cfg.init.step_we   = wr_en && (idx == mrg_pkg::REG_INITIAL_STEP);
    assign cfg.init.value     = $signed(pwdata[7:0]);

endmodule

`default_nettype wire

>>> sv/mrg_trig_table.sv
// trigger table with parallel note match, lowest slot wins
`default_nettype none

module mrg_trig_table (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire mrg_pkg::item_t item,
    output mrg_pkg::match_t     match
);

    logic                [mrg_pkg::TRIGGERS-1:0] valid_reg;
    mrg_pkg::trig_word_t                         words_reg [mrg_pkg::TRIGGERS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < mrg_pkg::TRIGGERS; i++)
            begin
                if (wr_en && (int'(item.slot) == i))
                begin
                    valid_reg[i] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < mrg_pkg::TRIGGERS; i++)
        begin
            if (wr_en && (int'(item.slot) == i))
            begin
                words_reg[i].note  <= item.note;
                words_reg[i].delay <= item.trig_delay;
                words_reg[i].start <= item.trig_start;
                words_reg[i].stop  <= item.trig_end;
                words_reg[i].step  <= item.trig_step;
            end
        end
    end

    always_comb
    begin
        match = '0;
        for (int i = mrg_pkg::TRIGGERS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (words_reg[i].note == item.note))
            begin
                match.hit   = 1'b1;
                match.delay = words_reg[i].delay;
                match.start = words_reg[i].start;
                match.stop  = words_reg[i].stop;
                match.step  = words_reg[i].step;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/mrg_ramp_core.sv
// ramp state, level computation and output register
`default_nettype none

module mrg_ramp_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mrg_pkg::cfg_t   cfg,
    input  wire logic            item_valid,
    input  wire mrg_pkg::item_t  item,
    input  wire mrg_pkg::match_t match,
    output logic                 fire,
    output logic                 trig_we,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [4:0]           cc_channel,
    output logic [6:0]           cc_control,
    output logic [6:0]           cc_value
);

    logic signed [7:0]  active_start_reg, active_start_next;
    logic signed [7:0]  active_end_reg,   active_end_next;
    logic signed [7:0]  active_step_reg,  active_step_next;
    logic [63:0]        ramp_begin_reg,   ramp_begin_next;
    logic [62:0]        previous_tick_reg, previous_tick_next;
    logic signed [7:0]  current_level_reg, current_level_next;
    logic signed [7:0]  last_sent_reg,    last_sent_next;
    logic               out_valid_reg,    out_valid_next;
    logic [4:0]         cc_channel_reg,   cc_channel_next;
    logic [6:0]         cc_control_reg,   cc_control_next;
    logic [6:0]         cc_value_reg,     cc_value_next;

    logic signed [64:0] diff;
    logic signed [9:0]  delta;
    logic signed [17:0] prod;
    logic signed [7:0]  lo;
    logic signed [7:0]  hi;
    logic signed [17:0] ramp_val;
    logic signed [17:0] lvl_in;
    logic [6:0]         lvl_out;
    logic               send_en;
    logic               emit;

    assign fire    = item_valid && (!out_valid_reg || out_ready);
    assign trig_we = fire && (item.func == mrg_pkg::FN_LOAD)
                     && (int'(item.slot) < mrg_pkg::TRIGGERS);

    // tick level: saturated time distance times step, clamped to start..end
    always_comb
    begin
        diff = $signed({2'b00, item.time_us}) - $signed({1'b0, ramp_begin_reg});
        if (diff > 65'sd256)
        begin
            delta = 10'sd256;
        end
        else if (diff < -65'sd256)
        begin
            delta = -10'sd256;
        end
        else
        begin
            delta = $signed(diff[9:0]);
        end
        prod = 18'(delta) * 18'(active_step_reg);
        if (active_start_reg < active_end_reg)
        begin
            lo = active_start_reg;
            hi = active_end_reg;
        end
        else
        begin
            lo = active_end_reg;
            hi = active_start_reg;
        end
        ramp_val = prod;
        if (ramp_val < 18'(lo))
        begin
            ramp_val = 18'(lo);
        end
        if (ramp_val > 18'(hi))
        begin
            ramp_val = 18'(hi);
        end
    end

    always_comb
    begin
        lvl_in  = ramp_val;
        send_en = 1'b0;
        active_start_next  = active_start_reg;
        active_end_next    = active_end_reg;
        active_step_next   = active_step_reg;
        ramp_begin_next    = ramp_begin_reg;
        previous_tick_next = previous_tick_reg;

        if (fire)
        begin
            unique case (item.func)
                mrg_pkg::FN_TICK:
                begin
                    send_en            = (ramp_begin_reg != 64'd0);
                    previous_tick_next = item.time_us;
                end
                mrg_pkg::FN_NOTE_ON:
                begin
                    if ((item.velocity >= cfg.min_velocity) && match.hit)
                    begin
                        ramp_begin_next  = 64'(previous_tick_reg) + 64'(match.delay);
                        active_start_next = match.start;
                        active_end_next   = match.stop;
                        active_step_next  = match.step;
                    end
                end
                mrg_pkg::FN_STEP_UP:
                begin
                    send_en = 1'b1;
                    lvl_in  = 18'(current_level_reg) + 18'(active_step_reg);
                end
                mrg_pkg::FN_STEP_DOWN:
                begin
                    send_en = 1'b1;
                    lvl_in  = 18'(current_level_reg) - 18'(active_step_reg);
                end
                mrg_pkg::FN_START:
                begin
                    ramp_begin_next = 64'd0;
                    send_en         = (active_start_reg >= 8'sd0);
                    lvl_in          = 18'(active_start_reg);
                end
                mrg_pkg::FN_END:
                begin
                    ramp_begin_next = 64'd0;
                    send_en         = (active_end_reg >= 8'sd0);
                    lvl_in          = 18'(active_end_reg);
                end
                default: ;
            endcase
        end

        if (cfg.init.start_we)
        begin
            active_start_next = cfg.init.value;
        end
        if (cfg.init.end_we)
        begin
            active_end_next = cfg.init.value;
        end
        if (cfg.init.step_we)
        begin
            active_step_next = cfg.init.value;
        end
    end

    // clamp to the midi range and send only on change
    always_comb
    begin
        if (lvl_in < 18'sd0)
        begin
            lvl_out = 7'd0;
        end
        else if (lvl_in > mrg_pkg::LEVEL_MAX)
        begin
            lvl_out = 7'd127;
        end
        else
        begin
            lvl_out = lvl_in[6:0];
        end
        emit = send_en && ($signed({1'b0, lvl_out}) != last_sent_reg);

        current_level_next = current_level_reg;
        last_sent_next     = last_sent_reg;
        if (send_en)
        begin
            current_level_next = $signed({1'b0, lvl_out});
        end
        if (emit)
        begin
            last_sent_next = $signed({1'b0, lvl_out});
        end
        if (cfg.init.start_we)
        begin
            current_level_next = cfg.init.value;
        end

        out_valid_next  = out_valid_reg && !out_ready;
        cc_channel_next = cc_channel_reg;
        cc_control_next = cc_control_reg;
        cc_value_next   = cc_value_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            cc_channel_next = cfg.midi_channel;
            cc_control_next = cfg.control_number;
            cc_value_next   = lvl_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_start_reg  <= mrg_pkg::RST_INITIAL_START;
            active_end_reg    <= mrg_pkg::RST_INITIAL_END;
            active_step_reg   <= mrg_pkg::RST_INITIAL_STEP;
            ramp_begin_reg    <= '0;
            previous_tick_reg <= '0;
            current_level_reg <= mrg_pkg::RST_INITIAL_START;
            last_sent_reg     <= mrg_pkg::RST_LAST_SENT;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            active_start_reg  <= active_start_next;
            active_end_reg    <= active_end_next;
            active_step_reg   <= active_step_next;
            ramp_begin_reg    <= ramp_begin_next;
            previous_tick_reg <= previous_tick_next;
            current_level_reg <= current_level_next;
            last_sent_reg     <= last_sent_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cc_channel_reg <= cc_channel_next;
        cc_control_reg <= cc_control_next;
        cc_value_reg   <= cc_value_next;
    end

    assign out_valid  = out_valid_reg;
    assign cc_channel = cc_channel_reg;
    assign cc_control = cc_control_reg;
    assign cc_value   = cc_value_reg;

endmodule

`default_nettype wire

>>> sv/midi_controller_ramp_generator.sv
// top level of the midi control-change ramp generator
//
// input channel (in_valid / in_ready) carries one command per transaction:
// tick, note on, step up, step down, start, end or trigger load.
// output channel (out_valid / out_ready) carries a control change
// transaction (cc_channel, cc_control, cc_value) only when the level changes.
// settings are written over the apb port; the user must write them only
// while the block is idle, which the block itself does not enforce.
// a transaction lands in an input register; once it fires, the whole
// update (one 65-bit time compare, one 10x8 multiply, clamps, and the
// parallel compare over the trigger table) is combinational and loads the
// output register; one transaction is taken every cycle unless stalled.
// when out_ready is low the result holds in the output register, one more
// transaction waits in the input register, and then in_ready drops.
// reset clears all trigger entries, restores the register defaults, idles
// the ramp and marks nothing as sent.
`default_nettype none

module midi_controller_ramp_generator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mrg_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [mrg_pkg::DATA_W-1:0]    pwdata,
    output logic      [mrg_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [2:0]                    func,
    input  wire logic [62:0]                   time_us,
    input  wire logic [6:0]                    note,
    input  wire logic [6:0]                    velocity,
    input  wire logic [2:0]                    slot,
    input  wire logic [31:0]                   trig_delay,
    input  wire logic signed [7:0]             trig_start,
    input  wire logic signed [7:0]             trig_end,
    input  wire logic signed [7:0]             trig_step,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [4:0]                         cc_channel,
    output logic [6:0]                         cc_control,
    output logic [6:0]                         cc_value
);

    mrg_pkg::cfg_t   cfg;
    mrg_pkg::item_t  item_reg;
    mrg_pkg::match_t match;
    logic            item_valid_reg;
    logic            fire;
    logic            trig_we;

    assign in_ready = !item_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.func       <= func;
            item_reg.time_us    <= time_us;
            item_reg.note       <= note;
            item_reg.velocity   <= velocity;
            item_reg.slot       <= slot;
            item_reg.trig_delay <= trig_delay;
            item_reg.trig_start <= trig_start;
            item_reg.trig_end   <= trig_end;
            item_reg.trig_step  <= trig_step;
        end
    end

    mrg_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mrg_trig_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (trig_we),
        .item  (item_reg),
        .match (match)
    );

    mrg_ramp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid_reg),
        .item       (item_reg),
        .match      (match),
        .fire       (fire),
        .trig_we    (trig_we),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cc_channel (cc_channel),
        .cc_control (cc_control),
        .cc_value   (cc_value)
    );

endmodule

`default_nettype wire

>>> verif/tb_midi_controller_ramp_generator.sv
// testbench for the midi control-change ramp generator: scoreboard class, drivers and checks
`timescale 1ns / 1ps

import mrg_pkg::*;

class cc_scoreboard;
    typedef struct {
        logic [4:0] ch;
        logic [6:0] ctl;
        logic [6:0] val;
    } cc_t;

    cc_t               pending_cc[$];
    int                errors;
    int                checked;
    int                accepted;
    int                ramp_ticks;

    logic [4:0]        midi_channel;
    logic [6:0]        control_number;
    logic [6:0]        min_velocity;
    logic signed [7:0] initial_start;
    logic signed [7:0] initial_end;
    logic signed [7:0] initial_step;

    bit                trig_valid[TRIGGERS];
    trig_word_t        trig_words[TRIGGERS];
    logic signed [7:0] act_start;
    logic signed [7:0] act_end;
    logic signed [7:0] act_step;
    logic [63:0]       ramp_begin;
    logic [63:0]       prev_tick;
    int                level;
    int                last_sent;

    function new();
        errors = 0;
        checked = 0;
        accepted = 0;
        ramp_ticks = 0;
        midi_channel = RST_MIDI_CHANNEL;
        control_number = RST_CONTROL_NUMBER;
        min_velocity = RST_MIN_VELOCITY;
        initial_start = RST_INITIAL_START;
        initial_end = RST_INITIAL_END;
        initial_step = RST_INITIAL_STEP;
        for (int i = 0; i < TRIGGERS; i++)
        begin
            trig_valid[i] = 1'b0;
            trig_words[i] = '0;
        end
        act_start = initial_start;
        act_end = initial_end;
        act_step = initial_step;
        ramp_begin = '0;
        prev_tick = '0;
        level = int'(initial_start);
        last_sent = -1;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] data);
        case (idx)
            REG_MIDI_CHANNEL:   midi_channel = data[4:0];
            REG_CONTROL_NUMBER: control_number = data[6:0];
            REG_MIN_VELOCITY:   min_velocity = data[6:0];
            REG_INITIAL_START:
            begin
                initial_start = data[7:0];
                act_start = initial_start;
                level = int'(initial_start);
            end
            REG_INITIAL_END:
            begin
                initial_end = data[7:0];
                act_end = initial_end;
            end
            REG_INITIAL_STEP:
            begin
                initial_step = data[7:0];
                act_step = initial_step;
            end
            default: ;
        endcase
    endfunction

    function void emit_level(int v);
        cc_t c;
        if (v < 0)
            v = 0;
        if (v > 127)
            v = 127;
        level = v;
        if (v != last_sent)
        begin
            last_sent = v;
            c.ch = midi_channel;
            c.ctl = control_number;
            c.val = v[6:0];
            pending_cc.push_back(c);
        end
    endfunction

    function void note_input(item_t it);
        logic [63:0] t64;
        logic [63:0] m;
        int          d;
        int          val;
        int          lo;
        int          hi;
        bit          found;
        accepted++;
        case (it.func)
            FN_TICK:
            begin
                t64 = {1'b0, it.time_us};
                if (ramp_begin != 0)
                begin
                    ramp_ticks++;
                    if (t64 >= ramp_begin)
                    begin
                        m = t64 - ramp_begin;
                        d = (m > 64'd256) ? 256 : int'(m);
                    end
                    else
                    begin
                        m = ramp_begin - t64;
                        d = (m > 64'd256) ? -256 : -int'(m);
                    end
                    val = d * int'(act_step);
                    lo = (act_start < act_end) ? int'(act_start) : int'(act_end);
                    hi = (act_start < act_end) ? int'(act_end) : int'(act_start);
                    if (val < lo)
                        val = lo;
                    if (val > hi)
                        val = hi;
                    emit_level(val);
                end
                prev_tick = t64;
            end
            FN_NOTE_ON:
            begin
                found = 1'b0;
                if (it.velocity >= min_velocity)
                begin
                    for (int i = 0; i < TRIGGERS; i++)
                    begin
                        if (!found && trig_valid[i] && trig_words[i].note == it.note)
                        begin
                            found = 1'b1;
                            ramp_begin = prev_tick + {32'b0, trig_words[i].delay};
                            act_start = trig_words[i].start;
                            act_end = trig_words[i].stop;
                            act_step = trig_words[i].step;
                        end
                    end
                end
            end
            FN_STEP_UP:   emit_level(level + int'(act_step));
            FN_STEP_DOWN: emit_level(level - int'(act_step));
            FN_START:
            begin
                ramp_begin = '0;
                if (act_start >= 0)
                    emit_level(int'(act_start));
            end
            FN_END:
            begin
                ramp_begin = '0;
                if (act_end >= 0)
                    emit_level(int'(act_end));
            end
            FN_LOAD:
            begin
                if (int'(it.slot) < TRIGGERS)
                begin
                    trig_valid[it.slot] = 1'b1;
                    trig_words[it.slot].note = it.note;
                    trig_words[it.slot].delay = it.trig_delay;
                    trig_words[it.slot].start = it.trig_start;
                    trig_words[it.slot].stop = it.trig_end;
                    trig_words[it.slot].step = it.trig_step;
                end
            end
            default: ;
        endcase
    endfunction

    function void check_result(logic [4:0] ch, logic [6:0] ctl, logic [6:0] val);
        cc_t c;
        checked++;
        if (pending_cc.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected cc transaction, expected none, got ch %0d ctl %0d val %0d",
                     $time, ch, ctl, val);
        end
        else
        begin
            c = pending_cc.pop_front();
            if (ch !== c.ch)
            begin
                errors++;
                $display("%0t: cc_channel expected %0d got %0d", $time, c.ch, ch);
            end
            if (ctl !== c.ctl)
            begin
                errors++;
                $display("%0t: cc_control expected %0d got %0d", $time, c.ctl, ctl);
            end
            if (val !== c.val)
            begin
                errors++;
                $display("%0t: cc_value expected %0d got %0d", $time, c.val, val);
            end
        end
    endfunction
endclass

module tb_midi_controller_ramp_generator;

    localparam logic [2:0] FN_UNUSED = 3'd7;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 325;
    localparam int CYCLE_LIMIT = 600000;

    logic                    clk;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_W-1:0]       paddr;
    logic [DATA_W-1:0]       pwdata;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    in_valid;
    logic                    in_ready;
    logic [2:0]              func;
    logic [62:0]             time_us;
    logic [6:0]              note;
    logic [6:0]              velocity;
    logic [2:0]              slot;
    logic [31:0]             trig_delay;
    logic signed [7:0]       trig_start;
    logic signed [7:0]       trig_end;
    logic signed [7:0]       trig_step;
    logic                    out_valid;
    logic                    out_ready;
    logic [4:0]              cc_channel;
    logic [6:0]              cc_control;
    logic [6:0]              cc_value;

    cc_scoreboard            sb;
    item_t                   mon_item;
    bit                      quiet;
    bit                      in_idle_en;
    bit                      out_idle_en;
    int                      cycles;

    midi_controller_ramp_generator u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .time_us    (time_us),
        .note       (note),
        .velocity   (velocity),
        .slot       (slot),
        .trig_delay (trig_delay),
        .trig_start (trig_start),
        .trig_end   (trig_end),
        .trig_step  (trig_step),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cc_channel (cc_channel),
        .cc_control (cc_control),
        .cc_value   (cc_value)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.pending_cc.size());
            $display("[midi_controller_ramp_generator] ERROR");
            $finish;
        end
    end

    // transaction monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(cc_channel, cc_control, cc_value);
            if (in_valid && in_ready)
            begin
                mon_item.func = func;
                mon_item.time_us = time_us;
                mon_item.note = note;
                mon_item.velocity = velocity;
                mon_item.slot = slot;
                mon_item.trig_delay = trig_delay;
                mon_item.trig_start = trig_start;
                mon_item.trig_end = trig_end;
                mon_item.trig_step = trig_step;
                sb.note_input(mon_item);
            end
        end
    end

    // output backpressure
    initial
    begin
        int stall_left;
        int span;
        stall_left = 0;
        span = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (span == 0)
            begin
                out_idle_en = ($urandom_range(0, 3) != 0);
                span = 256;
            end
            span--;
            if (quiet || !out_idle_en)
            begin
                out_ready <= 1'b1;
                stall_left = 0;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 18);
            end
        end
    end

    function automatic item_t mk(logic [2:0] f, logic [62:0] t, logic [6:0] n,
                                 logic [6:0] v, logic [2:0] s, logic [31:0] dly,
                                 logic signed [7:0] st, logic signed [7:0] en,
                                 logic signed [7:0] sp);
        item_t it;
        it.func = f;
        it.time_us = t;
        it.note = n;
        it.velocity = v;
        it.slot = s;
        it.trig_delay = dly;
        it.trig_start = st;
        it.trig_end = en;
        it.trig_step = sp;
        return it;
    endfunction

    task automatic drive(item_t it);
        in_valid <= 1'b1;
        func <= it.func;
        time_us <= it.time_us;
        note <= it.note;
        velocity <= it.velocity;
        slot <= it.slot;
        trig_delay <= it.trig_delay;
        trig_start <= it.trig_start;
        trig_end <= it.trig_end;
        trig_step <= it.trig_step;
        do
            @(posedge clk);
        while (!in_ready);
        if (!quiet && in_idle_en && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic apb_write(reg_idx_t idx, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic wait_idle();
        while (sb.pending_cc.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic configure(int p);
        int          ch;
        int          ctl;
        int          mv;
        int          st;
        int          en;
        int          sp;
        logic [31:0] d;
        ch = $urandom_range(1, 16);
        ctl = $urandom_range(0, 127);
        mv = $urandom_range(0, 127);
        st = $urandom_range(0, 128) - 1;
        en = $urandom_range(0, 128) - 1;
        sp = $urandom_range(0, 254) - 127;
        case (p)
            0:
            begin
                ch = 16; ctl = 127; mv = 127; st = 127; en = -1; sp = -127;
            end
            1:
            begin
                ch = 1; ctl = 0; mv = 0; st = -1; en = 127; sp = 127;
            end
            2:
            begin
                ch = 0; mv = 20; st = 0; en = 0; sp = 1;
            end
            3:
            begin
                ch = 31; sp = $urandom_range(0, 16) - 8;
            end
            default: ;
        endcase
        d = $urandom; d[4:0] = ch[4:0];
        apb_write(REG_MIDI_CHANNEL, d);
        d = $urandom; d[6:0] = ctl[6:0];
        apb_write(REG_CONTROL_NUMBER, d);
        d = $urandom; d[6:0] = mv[6:0];
        apb_write(REG_MIN_VELOCITY, d);
        d = $urandom; d[7:0] = st[7:0];
        apb_write(REG_INITIAL_START, d);
        d = $urandom; d[7:0] = en[7:0];
        apb_write(REG_INITIAL_END, d);
        d = $urandom; d[7:0] = sp[7:0];
        apb_write(REG_INITIAL_STEP, d);
    endtask

    function automatic item_t rand_item();
        item_t       it;
        int          r;
        int          sel;
        int          off;
        logic [63:0] t64;
        logic [2:0]  pick;
        it.func = FN_UNUSED;
        it.time_us = {$urandom, $urandom};
        it.note = $urandom;
        it.velocity = $urandom;
        it.slot = $urandom;
        it.trig_delay = $urandom;
        it.trig_start = $urandom;
        it.trig_end = $urandom;
        it.trig_step = $urandom;
        r = $urandom_range(0, 99);
        sel = $urandom_range(0, 9);
        pick = $urandom;
        if (r < 40)
        begin
            it.func = FN_TICK;
            if (sel == 0)
                it.time_us = {$urandom, $urandom};
            else if (sel <= 5)
            begin
                off = $urandom_range(0, 600) - 300;
                t64 = sb.ramp_begin + 64'(off);
                it.time_us = t64[62:0];
            end
            else
            begin
                t64 = sb.prev_tick + 64'($urandom_range(0, 60));
                it.time_us = t64[62:0];
            end
        end
        else if (r < 55)
        begin
            it.func = FN_NOTE_ON;
            if (sel < 7 && sb.trig_valid[pick])
                it.note = sb.trig_words[pick].note;
            else if (sel < 9)
                it.note = $urandom_range(0, 15);
            if (sel != 9)
                it.velocity = $urandom_range(int'(sb.min_velocity), 127);
        end
        else if (r < 63)
            it.func = FN_STEP_UP;
        else if (r < 71)
            it.func = FN_STEP_DOWN;
        else if (r < 76)
            it.func = FN_START;
        else if (r < 81)
            it.func = FN_END;
        else if (r < 97)
        begin
            it.func = FN_LOAD;
            if (sel < 8)
                it.note = $urandom_range(0, 15);
            case ($urandom_range(0, 9))
                0: it.trig_delay = '0;
                1: it.trig_delay = '1;
                2: ;
                default: it.trig_delay = $urandom_range(0, 200);
            endcase
            it.trig_start = $urandom_range(0, 128) - 1;
            it.trig_end = $urandom_range(0, 128) - 1;
            if (sel < 6)
                it.trig_step = $urandom_range(0, 16) - 8;
            else
                it.trig_step = $urandom_range(0, 254) - 127;
        end
        return it;
    endfunction

    initial
    begin
        int     n;
        item_t  it;
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        func = FN_TICK;
        time_us = '0;
        note = '0;
        velocity = '0;
        slot = '0;
        trig_delay = '0;
        trig_start = '0;
        trig_end = '0;
        trig_step = '0;
        quiet = 1'b0;
        in_idle_en = 1'b1;
        cycles = 0;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed sequence on reset settings
        drive(mk(FN_TICK, 63'd0, 7'd0, 7'd0, 3'd0, 32'd0, 0, 0, 0));
        drive(mk(FN_STEP_UP, 63'd0, 7'd0, 7'd0, 3'd0, 32'd0, 0, 0, 0));
        drive(mk(FN_START, 63'd0, 7'd0, 7'd0, 3'd0, 32'd0, 0, 0, 0));
        drive(mk(FN_END, 63'd0, 7'd0, 7'd0, 3'd0, 32'd0, 0, 0, 0));
        drive(mk(FN_LOAD, 63'd0, 7'd60, 7'd0, 3'd0, 32'd0, 10, 100, 3));
        // begin lands on zero, ramp stays idle
        drive(mk(FN_NOTE_ON, 63'd0, 7'd60, 7'd20, 3'd0, 32'd0, 0, 0, 0));
        drive(mk(FN_TICK, 63'd5, 7'd0, 7'd0, 3'd0, 32'd0, 0, 0, 0));
        drive(mk(FN_NOTE_ON, 63'd0, 7'd60, 7'd19, 3'd0, 32'd0, 0, 0, 0));
        drive(mk(FN_NOTE_ON, 63'd0, 7'd0, 7'd0, 3'd0, 32'd0, 0, 0, 0));
        // duplicate note in a higher slot
        drive(mk(FN_LOAD, 63'd0, 7'd60, 7'd0, 3'd7, 32'd100, 0, 127, 5));
        drive(mk(FN_LOAD, 63'd0, 7'd127, 7'd0, 3'd3, '1, 127, -1, -127));
        drive(mk(FN_LOAD, 63'd0, 7'd0, 7'd0, 3'd1, 32'd1, -1, 127, 127));
        drive(mk(FN_NOTE_ON, 63'd0, 7'd60, 7'd127, 3'd0, 32'd0, 0, 0, 0));
        // tick before begin, inside ramp, past saturation
        drive(mk(FN_TICK, 63'd3, 7'd0, 7'd0, 3'd0, 32'd0, 0, 0, 0));
        drive(mk(FN_TICK, 63'd30, 7'd0, 7'd0, 3'd0, 32'd0, 0, 0, 0));
        drive(mk(FN_TICK, 63'd1000, 7'd0, 7'd0, 3'd0, 32'd0, 0, 0, 0));
        drive(mk(FN_STEP_DOWN, 63'd0, 7'd0, 7'd0, 3'd0, 32'd0, 0, 0, 0));
        drive(mk(FN_STEP_UP, 63'd0, 7'd0, 7'd0, 3'd0, 32'd0, 0, 0, 0));
        drive(mk(FN_NOTE_ON, 63'd0, 7'd5, 7'd127, 3'd0, 32'd0, 0, 0, 0));
        drive(mk(FN_START, 63'd0, 7'd0, 7'd0, 3'd0, 32'd0, 0, 0, 0));
        drive(mk(FN_END, 63'd0, 7'd0, 7'd0, 3'd0, 32'd0, 0, 0, 0));
        drive(mk(FN_UNUSED, '1, '1, '1, '1, '1, -1, -1, -1));
        drive(mk(FN_TICK, '1, 7'd0, 7'd0, 3'd0, 32'd0, 0, 0, 0));
        // begin beyond the 63-bit time range
        drive(mk(FN_NOTE_ON, 63'd0, 7'd127, 7'd127, 3'd0, 32'd0, 0, 0, 0));
        drive(mk(FN_TICK, 63'd0, 7'd0, 7'd0, 3'd0, 32'd0, 0, 0, 0));
        drive(mk(FN_TICK, '1, 7'd0, 7'd0, 3'd0, 32'd0, 0, 0, 0));
        in_valid <= 1'b0;
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            configure(p);
            if (p == PHASES - 1)
                quiet = 1'b1;
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                if (n % 64 == 0)
                    in_idle_en = ($urandom_range(0, 3) != 0);
                it = rand_item();
                if (it.func != FN_UNUSED)
                    n++;
                drive(it);
            end
            in_valid <= 1'b0;
            wait_idle();
        end

        repeat (10) @(posedge clk);
        $display("covered %0d transactions in, %0d cc transactions out, %0d ticks on a live ramp",
                 sb.accepted, sb.checked, sb.ramp_ticks);
        $display("%0d setting phases plus the reset defaults, %0d cycles",
                 PHASES, cycles);
        if (sb.errors == 0 && sb.pending_cc.size() == 0)
            $display("[midi_controller_ramp_generator] OK");
        else
            $display("[midi_controller_ramp_generator] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
sv/mrg_pkg.sv
sv/mrg_apb_regs.sv
sv/mrg_trig_table.sv
sv/mrg_ramp_core.sv
sv/midi_controller_ramp_generator.sv
verif/tb_midi_controller_ramp_generator.sv
